@@ rtl/nba_pkg.sv @@
// Shared types and constants of the bitmap node allocator.
`timescale 1ns / 1ps

package nba_pkg;

    localparam int NODE_COUNT_W = 13;
    localparam int INDEX_W      = 16;
    localparam int STATUS_W     = 2;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 32;

    localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 13'd4096;
    localparam logic [INDEX_W-1:0]      FIRST_NODE_RESET = 16'd3;

    // register index, taken from paddr[2]
    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic REG_FIRST_NODE = 1'b1;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK          = 2'd0,
        STATUS_NO_MEM      = 2'd1,
        STATUS_RANGE       = 2'd2,
        STATUS_DOUBLE_FREE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HINT_MOD,
        S_ALLOC_CHK,
        S_REL_RANGE,
        S_REL_CHK
    } ctrl_state_t;

    typedef struct packed {
        logic    clear_step;
        logic    load_req;
        logic    mod_step;
        logic    scan_start;
        logic    scan_step;
        logic    rel_read;
        logic    commit_alloc;
        logic    commit_rel;
        logic    out_load;
        status_t out_status;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic count_zero;
        logic hint_ge_words;
        logic found;
        logic scan_last;
        logic rel_bad;
        logic bit_clear;
    } dp_status_t;

endpackage

@@ rtl/nba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module nba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/nba_cfg.sv @@
// APB register file: node count and external index of node zero.
`timescale 1ns / 1ps

module nba_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [nba_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [nba_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [nba_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready,
    output logic [nba_pkg::NODE_COUNT_W-1:0]   node_count,
    output logic [nba_pkg::INDEX_W-1:0]        first_node_index
);

    logic [nba_pkg::NODE_COUNT_W-1:0] node_count_reg;
    logic [nba_pkg::INDEX_W-1:0]      first_node_reg;
    logic                             wr_en;

    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= nba_pkg::NODE_COUNT_RESET;
            first_node_reg <= nba_pkg::FIRST_NODE_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == nba_pkg::REG_NODE_COUNT)
            begin
                node_count_reg <= pwdata[nba_pkg::NODE_COUNT_W-1:0];
            end
            else
            begin
                first_node_reg <= pwdata[nba_pkg::INDEX_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == nba_pkg::REG_NODE_COUNT)
        begin
            prdata = nba_pkg::CFG_DATA_W'(node_count_reg);
        end
        else
        begin
            prdata = nba_pkg::CFG_DATA_W'(first_node_reg);
        end
    end

    assign pready           = 1'b1;
    assign node_count       = node_count_reg;
    assign first_node_index = first_node_reg;

endmodule

@@ rtl/nba_dp.sv @@
// Datapath: bitmap RAM, scan pointer, hint, release decode and result registers.
`timescale 1ns / 1ps

module nba_dp #(
    parameter int MAX_NODES = 4096,
    parameter int WORD_BITS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  nba_pkg::dp_cmd_t                 cmd,
    output nba_pkg::dp_status_t              dp_status,
    input  logic [nba_pkg::INDEX_W-1:0]      release_index,
    input  logic [nba_pkg::NODE_COUNT_W-1:0] node_count,
    input  logic [nba_pkg::INDEX_W-1:0]      first_node_index,
    output logic [nba_pkg::STATUS_W-1:0]     status,
    output logic [nba_pkg::INDEX_W-1:0]      granted_index
);

    // WORD_BITS is a power of two
    localparam int NWORDS  = (MAX_NODES + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W  = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int WCNT_W  = $clog2(NWORDS + 1);
    localparam int BIT_W   = $clog2(WORD_BITS);
    localparam int NODE_W  = $clog2(MAX_NODES + 1);
    localparam int CMP_W   = (NODE_W > nba_pkg::INDEX_W) ? NODE_W : nba_pkg::INDEX_W;
    localparam int GSUM_W  = CMP_W + 1;

    logic [WIDX_W-1:0]          clr_addr_reg;
    logic [WIDX_W-1:0]          hint_reg;
    logic [WIDX_W-1:0]          cur_w_reg;
    logic [WCNT_W-1:0]          scan_left_reg;
    logic [nba_pkg::INDEX_W-1:0] req_index_reg;
    nba_pkg::status_t           status_reg;
    logic [nba_pkg::INDEX_W-1:0] granted_reg;

    logic [NODE_W-1:0]          count;
    logic [NODE_W:0]            words_sum;
    logic [WCNT_W-1:0]          words;
    logic [WCNT_W-1:0]          cur_w_ext;
    logic [WCNT_W-1:0]          cur_w_inc;
    logic [WIDX_W-1:0]          next_w;
    logic [NODE_W-1:0]          base;
    logic [NODE_W-1:0]          rem;
    logic [WORD_BITS-1:0]       rdata;
    logic [WORD_BITS-1:0]       free_bits;
    logic [BIT_W-1:0]           sel_bit;
    logic                       found;
    logic [GSUM_W-1:0]          grant_sum;
    logic [nba_pkg::INDEX_W:0]  rel_diff;
    logic [nba_pkg::INDEX_W-1:0] rel_node;
    logic [WIDX_W-1:0]          rel_w;
    logic [BIT_W-1:0]           rel_b;

    logic                       ram_we;
    logic [WIDX_W-1:0]          ram_waddr;
    logic [WORD_BITS-1:0]       ram_wdata;
    logic                       ram_re;
    logic [WIDX_W-1:0]          ram_raddr;

    // active node count, clamped to the bitmap size
    always_comb
    begin
        if (32'(node_count) > MAX_NODES)
        begin
            count = NODE_W'(MAX_NODES);
        end
        else
        begin
            count = NODE_W'(node_count);
        end
    end

    assign words_sum = (NODE_W + 1)'(count) + (NODE_W + 1)'(WORD_BITS - 1);
    assign words     = WCNT_W'(words_sum >> BIT_W);
    assign cur_w_ext = WCNT_W'(cur_w_reg);
    assign cur_w_inc = cur_w_ext + WCNT_W'(1);
    assign next_w    = (cur_w_inc == words) ? '0 : WIDX_W'(cur_w_inc);

    // first node of the word under scan and nodes left from it
    assign base = NODE_W'({cur_w_reg, {BIT_W{1'b0}}});
    assign rem  = count - base;

    // lowest clear bit among in-range nodes
    always_comb
    begin
        free_bits = '0;
        sel_bit   = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            free_bits[b] = !rdata[b] && (rem > NODE_W'(b));
        end
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (free_bits[b])
            begin
                sel_bit = BIT_W'(b);
            end
        end
    end

    assign found     = |free_bits;
    assign grant_sum = GSUM_W'(base) + GSUM_W'(sel_bit) + GSUM_W'(first_node_index);

    // release: external index to node, word and bit
    assign rel_diff = {1'b0, req_index_reg} - {1'b0, first_node_index};
    assign rel_node = rel_diff[nba_pkg::INDEX_W-1:0];
    assign rel_w    = WIDX_W'(rel_node >> BIT_W);
    assign rel_b    = rel_node[BIT_W-1:0];

    assign dp_status.clear_last    = (clr_addr_reg == WIDX_W'(NWORDS - 1));
    assign dp_status.count_zero    = (count == '0);
    assign dp_status.hint_ge_words = (cur_w_ext >= words);
    assign dp_status.found         = found;
    assign dp_status.scan_last     = (scan_left_reg == WCNT_W'(1));
    assign dp_status.rel_bad       = rel_diff[nba_pkg::INDEX_W]
                                     || (CMP_W'(rel_node) >= CMP_W'(count));
    assign dp_status.bit_clear     = !rdata[rel_b];

    // RAM port steering
    always_comb
    begin
        ram_we    = cmd.clear_step || cmd.commit_alloc || cmd.commit_rel;
        ram_waddr = rel_w;
        ram_wdata = rdata & ~(WORD_BITS'(1) << rel_b);
        if (cmd.clear_step)
        begin
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else if (cmd.commit_alloc)
        begin
            ram_waddr = cur_w_reg;
            ram_wdata = rdata | (WORD_BITS'(1) << sel_bit);
        end

        ram_re    = cmd.scan_start || cmd.scan_step || cmd.rel_read;
        ram_raddr = rel_w;
        if (cmd.scan_start)
        begin
            ram_raddr = cur_w_reg;
        end
        else if (cmd.scan_step)
        begin
            ram_raddr = next_w;
        end
    end

    nba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NWORDS)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            hint_reg     <= '0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_addr_reg <= clr_addr_reg + WIDX_W'(1);
            end
            if (cmd.commit_rel)
            begin
                hint_reg <= rel_w;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_index_reg <= release_index;
            cur_w_reg     <= hint_reg;
        end
        else if (cmd.mod_step)
        begin
            cur_w_reg <= WIDX_W'(cur_w_ext - words);
        end
        else if (cmd.scan_step)
        begin
            cur_w_reg <= next_w;
        end

        if (cmd.scan_start)
        begin
            scan_left_reg <= words;
        end
        else if (cmd.scan_step)
        begin
            scan_left_reg <= scan_left_reg - WCNT_W'(1);
        end

        if (cmd.out_load)
        begin
            status_reg  <= cmd.out_status;
            granted_reg <= cmd.commit_alloc ? grant_sum[nba_pkg::INDEX_W-1:0] : '0;
        end
    end

    assign status        = status_reg;
    assign granted_index = granted_reg;

    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clear_step, cmd.commit_alloc, cmd.commit_rel}))
        else $error("more than one bitmap write source");

    a_alloc_found: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit_alloc |-> (found && cmd.out_load && cmd.out_status == nba_pkg::STATUS_OK))
        else $error("allocation committed without a free bit");

endmodule

@@ rtl/nba_ctrl.sv @@
// Controller: clearing pass, request sequencing and response handshake.
`timescale 1ns / 1ps

module nba_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_opcode,
    output logic                req_stall,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    input  nba_pkg::dp_status_t dp_status,
    output nba_pkg::dp_cmd_t    cmd
);

    nba_pkg::ctrl_state_t state_reg;
    nba_pkg::ctrl_state_t state_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    logic                 out_free;

    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nba_pkg::S_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.out_status = nba_pkg::STATUS_OK;
        case (state_reg)
            nba_pkg::S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (dp_status.clear_last)
                begin
                    state_next = nba_pkg::S_IDLE;
                end
            end
            nba_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    if (req_opcode == nba_pkg::OP_RELEASE)
                    begin
                        state_next = nba_pkg::S_REL_RANGE;
                    end
                    else
                    begin
                        state_next = nba_pkg::S_HINT_MOD;
                    end
                end
            end
            nba_pkg::S_HINT_MOD:
            begin
                if (dp_status.count_zero)
                begin
                    if (out_free)
                    begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = nba_pkg::STATUS_NO_MEM;
                        state_next     = nba_pkg::S_IDLE;
                    end
                end
                else if (dp_status.hint_ge_words)
                begin
                    cmd.mod_step = 1'b1;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = nba_pkg::S_ALLOC_CHK;
                end
            end
            nba_pkg::S_ALLOC_CHK:
            begin
                if (dp_status.found)
                begin
                    if (out_free)
                    begin
                        cmd.commit_alloc = 1'b1;
                        cmd.out_load     = 1'b1;
                        cmd.out_status   = nba_pkg::STATUS_OK;
                        state_next       = nba_pkg::S_IDLE;
                    end
                end
                else if (dp_status.scan_last)
                begin
                    if (out_free)
                    begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = nba_pkg::STATUS_NO_MEM;
                        state_next     = nba_pkg::S_IDLE;
                    end
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            nba_pkg::S_REL_RANGE:
            begin
                if (dp_status.rel_bad)
                begin
                    if (out_free)
                    begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = nba_pkg::STATUS_RANGE;
                        state_next     = nba_pkg::S_IDLE;
                    end
                end
                else
                begin
                    cmd.rel_read = 1'b1;
                    state_next   = nba_pkg::S_REL_CHK;
                end
            end
            nba_pkg::S_REL_CHK:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = nba_pkg::S_IDLE;
                    if (dp_status.bit_clear)
                    begin
                        cmd.out_status = nba_pkg::STATUS_DOUBLE_FREE;
                    end
                    else
                    begin
                        cmd.commit_rel = 1'b1;
                        cmd.out_status = nba_pkg::STATUS_OK;
                    end
                end
            end
            default:
            begin
                state_next = nba_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    assign req_stall = (state_reg != nba_pkg::S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!rsp_valid_reg || !rsp_stall))
        else $error("response register overwritten while stalled");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nba_pkg::S_IDLE && req_valid) |=> (state_reg != nba_pkg::S_IDLE))
        else $error("accepted request did not start");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nba_pkg::S_CLEAR) |-> (!rsp_valid_reg && !cmd.load_req))
        else $error("activity during clearing pass");

endmodule

@@ rtl/bitmap_node_allocator_top.sv @@
// Top level of the bitmap node allocator: config port, controller and datapath.
`timescale 1ns / 1ps

// Usage
//   Request channel (req_valid / req_stall, opcode, release_index): a transaction
//   is taken at a rising edge with req_valid high and req_stall low. opcode 0
//   allocates a node, opcode 1 releases the node named by release_index.
//   Response channel (rsp_valid / rsp_stall, status, granted_index): one
//   transaction per request, in request order, held stable while stalled.
//   Throughput: one request at a time. A release checks its range, then reads
//   the bitmap word and checks the bit; out of range, it answers after the
//   range check alone. An allocate scans bitmap words (one word read per cycle,
//   starting at the hint word and wrapping), first subtracting the active-word
//   count from the hint while the hint lies at or beyond the active words;
//   with zero nodes it does not scan. req_stall is low only in the idle state.
//   A finished response sits in the output register; a new request may be
//   accepted while it waits. If rsp_stall keeps the register full, the next
//   request holds in its last step until the register frees.
//   Reset: a clearing pass writes every bitmap word to all free, one word per
//   cycle; requests are stalled meanwhile, APB writes are taken at any time.
//   Config (APB): node_count at 0x0, first_node_index at 0x4; write only
//   while idle. WORD_BITS must be a power of two.

module bitmap_node_allocator_top #(
    parameter int MAX_NODES = 4096,
    parameter int WORD_BITS = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic                               opcode,
    input  logic [nba_pkg::INDEX_W-1:0]        release_index,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic [nba_pkg::STATUS_W-1:0]       status,
    output logic [nba_pkg::INDEX_W-1:0]        granted_index,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [nba_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [nba_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [nba_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready
);

    logic [nba_pkg::NODE_COUNT_W-1:0] node_count;
    logic [nba_pkg::INDEX_W-1:0]      first_node_index;
    nba_pkg::dp_cmd_t                 cmd;
    nba_pkg::dp_status_t              dp_status;

    // register file
    nba_cfg u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .node_count       (node_count),
        .first_node_index (first_node_index)
    );

    // sequence each transaction through the datapath
    nba_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_opcode (opcode),
        .req_stall  (req_stall),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .dp_status  (dp_status),
        .cmd        (cmd)
    );

    // bitmap storage, scan and result registers
    nba_dp #(
        .MAX_NODES (MAX_NODES),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .dp_status        (dp_status),
        .release_index    (release_index),
        .node_count       (node_count),
        .first_node_index (first_node_index),
        .status           (status),
        .granted_index    (granted_index)
    );

endmodule
